// ===== rtl/overvoltage_alarm_trip_relay_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Overvoltage relay assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef OVERVOLTAGE_ALARM_TRIP_RELAY_UNIT_MACROS_SVH
`define OVERVOLTAGE_ALARM_TRIP_RELAY_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define OVTR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("overvoltage relay check failed");

// next-cycle implication, disabled during reset
`define OVTR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("overvoltage relay check failed");

`endif

// ===== rtl/ovtr_pkg.sv =====
// ---------------------------------------------------------------------------
// Overvoltage relay package
// Payload types, status codes, register indexes and the update control.
// ---------------------------------------------------------------------------
package ovtr_pkg;

   localparam int PHASE_W  = 2;
   localparam int VOLT_W   = 32;
   localparam int NOW_W    = 48;
   localparam int STATUS_W = 3;
   localparam int CSR_W    = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_SAFE         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALARM_TIMING = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ALARM        = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TRIP_TIMING  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TRIP_NOW     = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_OPEN         = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIP_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_PERIOD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIP_PERIOD  = 2'd3;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [VOLT_W-1:0]  voltage;
      logic [NOW_W-1:0]   now;
      logic               breaker_closed;
   } req_type;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase_out;
      logic [STATUS_W-1:0] status;
      logic                alarm;
      logic                trip;
   } rsp_type;

   typedef struct packed {
      logic trip_set;
      logic trip_clr;
      logic alarm_set;
      logic alarm_clr;
      logic latch;
   } upd_type;

endpackage

// ===== rtl/overvoltage_alarm_trip_relay_unit.sv =====
// ---------------------------------------------------------------------------
// Overvoltage alarm and trip relay
// Definite-time overvoltage relay for one three-phase breaker.
// ---------------------------------------------------------------------------
// Usage:
//   req_ carries one voltage sample per beat (phase, voltage, timestamp,
//   breaker state); rsp_ returns exactly one result beat per sample, in
//   order: echoed phase, status code, alarm flag and the trip latch.
//   csr_ writes the limits and periods; write only while the block is idle.
// Timing:
//   A sample is registered on acceptance and evaluated in the next cycle,
//   where one 48-bit subtract and compare per timer decides the status and
//   the timer update; the result is registered. Throughput is one beat per
//   cycle while the result is not stalled: the input register refills in
//   the same cycle its sample moves to the result register.
// Reset:
//   Clears all timers, the trip latch, both valid flags and the registers
//   to their defaults (trip limit all ones, the rest zero).
// Stall:
//   While rsp_ready is low the result holds; one more sample is taken into
//   the input register, then req_ready drops until the result is taken.
// ---------------------------------------------------------------------------
`include "overvoltage_alarm_trip_relay_unit_macros.svh"

module overvoltage_alarm_trip_relay_unit
   import ovtr_pkg::*;
#(
   parameter int NUM_PHASES = 3,
   parameter int TIME_WIDTH = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int PIDX_W = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   req_type               s1_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic [VOLT_W-1:0]     alarm_limit_ff;
   logic [VOLT_W-1:0]     trip_limit_ff;
   logic [CSR_W-1:0]      alarm_period_ff;
   logic [CSR_W-1:0]      trip_period_ff;

   logic                  advance;
   logic                  in_range;
   logic [PIDX_W-1:0]     idx;
   logic                  trip_running;
   logic [TIME_WIDTH-1:0] trip_start;
   logic                  alarm_running;
   logic [TIME_WIDTH-1:0] alarm_start;
   logic                  tripped;
   logic [STATUS_W-1:0]   status;
   logic                  alarm;
   upd_type               upd;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign in_range     = 32'(s1_ff.phase) < 32'(NUM_PHASES);
   assign idx          = PIDX_W'(s1_ff.phase);

   assign rsp_in.phase_out = s1_ff.phase;
   assign rsp_in.status    = status;
   assign rsp_in.alarm     = alarm;
   assign rsp_in.trip      = tripped | upd.latch;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   ovtr_state #(
      .NUM_PHASES (NUM_PHASES),
      .TIME_WIDTH (TIME_WIDTH),
      .PIDX_W     (PIDX_W)
   ) u_state (
      .clock         (clock),
      .reset         (reset),
      .update        (advance),
      .idx           (idx),
      .now           (s1_ff.now),
      .upd           (upd),
      .trip_running  (trip_running),
      .trip_start    (trip_start),
      .alarm_running (alarm_running),
      .alarm_start   (alarm_start),
      .tripped       (tripped)
   );

   ovtr_eval #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_eval (
      .sample        (s1_ff),
      .in_range      (in_range),
      .tripped       (tripped),
      .trip_running  (trip_running),
      .trip_start    (trip_start),
      .alarm_running (alarm_running),
      .alarm_start   (alarm_start),
      .alarm_limit   (alarm_limit_ff),
      .trip_limit    (trip_limit_ff),
      .alarm_period  (alarm_period_ff),
      .trip_period   (trip_period_ff),
      .status        (status),
      .alarm         (alarm),
      .upd           (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         alarm_limit_ff  <= '0;
         trip_limit_ff   <= '1;
         alarm_period_ff <= '0;
         trip_period_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ALARM_LIMIT:  alarm_limit_ff  <= csr_wdata[VOLT_W-1:0];
               CSR_TRIP_LIMIT:   trip_limit_ff   <= csr_wdata[VOLT_W-1:0];
               CSR_ALARM_PERIOD: alarm_period_ff <= csr_wdata;
               CSR_TRIP_PERIOD:  trip_period_ff  <= csr_wdata;
               default:          alarm_limit_ff  <= alarm_limit_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   `OVTR_ASSERT_SAME(a_alarm_status, clock, reset, rsp_valid_ff, rsp_ff.alarm == (rsp_ff.status == STATUS_ALARM))
   `OVTR_ASSERT_SAME(a_trip_now_latched, clock, reset, rsp_valid_ff && (rsp_ff.status == STATUS_TRIP_NOW), rsp_ff.trip)
   `OVTR_ASSERT_NEXT(a_latch_sticky, clock, reset, tripped, tripped)
   `OVTR_ASSERT_NEXT(a_held_sample, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_ff))

endmodule

// ===== rtl/ovtr_eval.sv =====
// ---------------------------------------------------------------------------
// Overvoltage relay evaluation
// Band classification, elapsed-time compares and timer update decision.
// ---------------------------------------------------------------------------
module ovtr_eval
   import ovtr_pkg::*;
#(
   parameter int TIME_WIDTH = 48
) (
   input  req_type               sample,
   input  logic                  in_range,
   input  logic                  tripped,
   input  logic                  trip_running,
   input  logic [TIME_WIDTH-1:0] trip_start,
   input  logic                  alarm_running,
   input  logic [TIME_WIDTH-1:0] alarm_start,
   input  logic [VOLT_W-1:0]     alarm_limit,
   input  logic [VOLT_W-1:0]     trip_limit,
   input  logic [CSR_W-1:0]      alarm_period,
   input  logic [CSR_W-1:0]      trip_period,
   output logic [STATUS_W-1:0]   status,
   output logic                  alarm,
   output upd_type               upd
);

   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] trip_elapsed;
   logic [TIME_WIDTH-1:0] alarm_elapsed;
   logic                  trip_due;
   logic                  alarm_due;

   assign now_t         = TIME_WIDTH'(sample.now);
   assign trip_elapsed  = now_t - trip_start;
   assign alarm_elapsed = now_t - alarm_start;
   assign trip_due      = trip_elapsed >= TIME_WIDTH'(trip_period);
   assign alarm_due     = alarm_elapsed >= TIME_WIDTH'(alarm_period);

   always_comb begin
      upd    = '0;
      status = STATUS_SAFE;
      alarm  = 1'b0;
      priority if (!in_range) begin
         status = STATUS_SAFE;
      end else if (!sample.breaker_closed || tripped) begin
         status = STATUS_OPEN;
      end else if (sample.voltage > trip_limit) begin
         priority if (!trip_running) begin
            upd.trip_set = 1'b1;
            status       = STATUS_TRIP_TIMING;
         end else if (trip_due) begin
            upd.latch = 1'b1;
            status    = STATUS_TRIP_NOW;
         end else begin
            status = STATUS_TRIP_TIMING;
         end
      end else if (sample.voltage >= alarm_limit) begin
         upd.trip_clr = 1'b1;
         priority if (!alarm_running) begin
            upd.alarm_set = 1'b1;
            status        = STATUS_ALARM_TIMING;
         end else if (alarm_due) begin
            status = STATUS_ALARM;
            alarm  = 1'b1;
         end else begin
            status = STATUS_ALARM_TIMING;
         end
      end else begin
         upd.trip_clr  = 1'b1;
         upd.alarm_clr = 1'b1;
      end
   end

endmodule

// ===== rtl/ovtr_state.sv =====
// ---------------------------------------------------------------------------
// Overvoltage relay timer state
// Per-phase trip and alarm timers and the trip latch.
// ---------------------------------------------------------------------------
module ovtr_state
   import ovtr_pkg::*;
#(
   parameter int NUM_PHASES = 3,
   parameter int TIME_WIDTH = 48,
   parameter int PIDX_W     = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  logic [PIDX_W-1:0]     idx,
   input  logic [NOW_W-1:0]      now,
   input  upd_type               upd,
   output logic                  trip_running,
   output logic [TIME_WIDTH-1:0] trip_start,
   output logic                  alarm_running,
   output logic [TIME_WIDTH-1:0] alarm_start,
   output logic                  tripped
);

   logic [NUM_PHASES-1:0] trip_run_ff;
   logic [NUM_PHASES-1:0] alarm_run_ff;
   logic [TIME_WIDTH-1:0] trip_start_ff  [NUM_PHASES];
   logic [TIME_WIDTH-1:0] alarm_start_ff [NUM_PHASES];
   logic                  tripped_ff;
   logic                  tripped_in;

   assign trip_running  = trip_run_ff[idx];
   assign alarm_running = alarm_run_ff[idx];
   assign trip_start    = trip_start_ff[idx];
   assign alarm_start   = alarm_start_ff[idx];
   assign tripped       = tripped_ff;
   assign tripped_in    = tripped_ff | (update & upd.latch);

   always_ff @(posedge clock) begin
      if (reset) begin
         trip_run_ff  <= '0;
         alarm_run_ff <= '0;
         tripped_ff   <= 1'b0;
      end else begin
         tripped_ff <= tripped_in;
         for (int p = 0; p < NUM_PHASES; p++) begin
            if (update && (idx == PIDX_W'(p))) begin
               if (upd.trip_set) begin
                  trip_run_ff[p] <= 1'b1;
               end else if (upd.trip_clr) begin
                  trip_run_ff[p] <= 1'b0;
               end
               if (upd.alarm_set) begin
                  alarm_run_ff[p] <= 1'b1;
               end else if (upd.alarm_clr) begin
                  alarm_run_ff[p] <= 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (update && (idx == PIDX_W'(p))) begin
            if (upd.trip_set) begin
               trip_start_ff[p] <= TIME_WIDTH'(now);
            end
            if (upd.alarm_set) begin
               alarm_start_ff[p] <= TIME_WIDTH'(now);
            end
         end
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Overvoltage relay testbench
// Streams voltage samples through the relay under several limit and period
// settings. Every accepted sample is run through a local copy of the relay
// logic, and the status beats that come back are compared field by field, in
// order. The sender works in random bursts and the receiver stalls on its own
// pattern, with recurring long hold-offs that back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ovtr_pkg::*;

   localparam int NPH          = 3;
   localparam int HALF_PERIOD  = 2;
   localparam int LIMIT_CYCLES = 400000;
   localparam logic [VOLT_W-1:0] V_MAX = '1;
   localparam logic [NOW_W-1:0]  T_MAX = '1;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ALARM_LIMIT;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // relay settings and per-phase timers as the block should hold them
   logic [VOLT_W-1:0] lim_alarm = '0;
   logic [VOLT_W-1:0] lim_trip  = '1;
   logic [NOW_W-1:0]  per_alarm = '0;
   logic [NOW_W-1:0]  per_trip  = '0;
   logic [NOW_W-1:0]  trip_t0  [NPH] = '{default: '0};
   logic              trip_on  [NPH] = '{default: 1'b0};
   logic [NOW_W-1:0]  alarm_t0 [NPH] = '{default: '0};
   logic              alarm_on [NPH] = '{default: 1'b0};
   logic              latched = 1'b0;

   req_type sample_q[$];
   rsp_type status_due_q[$];

   logic [NOW_W-1:0] gen_t [NPH] = '{default: '0};
   int unsigned      adv_max = 1;

   int      burst_left   = 1;
   int      gap_left     = 0;
   int      ready_left   = 0;
   int      stall_left   = 0;
   int      hold_left    = 0;
   int      next_hold_at = 400;
   int      rsp_beats    = 0;
   int      mismatches   = 0;
   int      cycles       = 0;
   rsp_type want;

   overvoltage_alarm_trip_relay_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic rsp_type relay_eval(req_type s);
      rsp_type          r;
      int               p;
      logic [NOW_W-1:0] dt;
      r.phase_out = s.phase;
      r.status    = STATUS_SAFE;
      r.alarm     = 1'b0;
      if (s.phase < NPH) begin
         p = int'(s.phase);
         if (!s.breaker_closed || latched) begin
            r.status = STATUS_OPEN;
         end else if (s.voltage > lim_trip) begin
            if (!trip_on[p]) begin
               trip_on[p] = 1'b1;
               trip_t0[p] = s.now;
               r.status   = STATUS_TRIP_TIMING;
            end else begin
               dt = s.now - trip_t0[p];
               if (dt >= per_trip) begin
                  latched  = 1'b1;
                  r.status = STATUS_TRIP_NOW;
               end else begin
                  r.status = STATUS_TRIP_TIMING;
               end
            end
         end else if (s.voltage >= lim_alarm) begin
            trip_on[p] = 1'b0;
            trip_t0[p] = '0;
            if (!alarm_on[p]) begin
               alarm_on[p] = 1'b1;
               alarm_t0[p] = s.now;
               r.status    = STATUS_ALARM_TIMING;
            end else begin
               dt = s.now - alarm_t0[p];
               if (dt >= per_alarm) begin
                  r.status = STATUS_ALARM;
                  r.alarm  = 1'b1;
               end else begin
                  r.status = STATUS_ALARM_TIMING;
               end
            end
         end else begin
            trip_on[p]  = 1'b0;
            trip_t0[p]  = '0;
            alarm_on[p] = 1'b0;
            alarm_t0[p] = '0;
         end
      end
      r.trip = latched;
      return r;
   endfunction

   // band: 0 below alarm, 1 at alarm limit, 2 alarm band, 3 at trip limit,
   // 4 above trip, otherwise anywhere
   function automatic logic [VOLT_W-1:0] pick_voltage(int band);
      logic [VOLT_W-1:0] v;
      v = $urandom;
      case (band)
         0: if (lim_alarm != '0) v = $urandom_range(lim_alarm - 1, 0);
         1: v = lim_alarm;
         2: if (lim_alarm <= lim_trip) v = $urandom_range(lim_trip, lim_alarm);
            else v = lim_alarm;
         3: v = lim_trip;
         4: if (lim_trip != V_MAX) v = $urandom_range(V_MAX, lim_trip + 1);
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_sample(int p, logic [VOLT_W-1:0] v, logic [NOW_W-1:0] t, bit closed);
      req_type s;
      s.phase          = p[PHASE_W-1:0];
      s.voltage        = v;
      s.now            = t;
      s.breaker_closed = closed;
      sample_q.insert(sample_q.size(), s);
   endtask

   // runs of one phase held in one band, with some malformed samples mixed in;
   // samples above the trip limit stay on the phase's own slow clock
   task automatic random_stream(int count);
      int      made;
      int      p;
      int      band;
      int      run;
      req_type s;
      made = 0;
      while (made < count) begin
         p    = $urandom_range(NPH - 1, 0);
         band = $urandom_range(5, 0);
         run  = $urandom_range(8, 1);
         repeat (run) begin
            gen_t[p]         = gen_t[p] + NOW_W'($urandom_range(adv_max, 0));
            s.phase          = p[PHASE_W-1:0];
            s.voltage        = pick_voltage(band);
            s.now            = gen_t[p];
            s.breaker_closed = ($urandom_range(19, 0) != 0);
            if ($urandom_range(6, 0) == 0) begin
               s.phase          = PHASE_W'($urandom_range(3, 0));
               s.voltage        = $urandom;
               s.now            = {16'($urandom), $urandom};
               s.breaker_closed = 1'($urandom_range(1, 0));
               if (s.phase < NPH && s.voltage > lim_trip) s.now = gen_t[s.phase];
            end
            sample_q.insert(sample_q.size(), s);
            if (s.phase < NPH) made++;
         end
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ALARM_LIMIT:  lim_alarm = val[VOLT_W-1:0];
         CSR_TRIP_LIMIT:   lim_trip  = val[VOLT_W-1:0];
         CSR_ALARM_PERIOD: per_alarm = val[NOW_W-1:0];
         CSR_TRIP_PERIOD:  per_trip  = val[NOW_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic [VOLT_W-1:0] al, logic [VOLT_W-1:0] tl,
                                logic [NOW_W-1:0] ap, logic [NOW_W-1:0] tp);
      write_reg(CSR_ALARM_LIMIT, {16'($urandom), al});
      write_reg(CSR_TRIP_LIMIT, {16'($urandom), tl});
      write_reg(CSR_ALARM_PERIOD, ap);
      write_reg(CSR_TRIP_PERIOD, tp);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_valid || status_due_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            status_due_q.insert(status_due_q.size(), relay_eval(req_data));
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || sample_q.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= sample_q.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 50)
                                                           : $urandom_range(12, 1);
                  gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
               end
            end
         end
      end
   end

   // receiver: own ready pattern plus a long hold-off every few hundred beats
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_beats >= next_hold_at) begin
         hold_left    = 150;
         next_hold_at = next_hold_at + 700;
         rsp_ready   <= 1'b0;
      end else if (ready_left > 0) begin
         ready_left--;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         ready_left = ($urandom_range(3, 0) == 0) ? $urandom_range(120, 40)
                                                  : $urandom_range(10, 1);
         stall_left = $urandom_range(4, 0);
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beats <= rsp_beats + 1;
         if (status_due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: phase %0d status %0d alarm %b trip %b",
                        rsp_data.phase_out, rsp_data.status, rsp_data.alarm, rsp_data.trip);
         end else begin
            want = status_due_q.pop_front();
            if (rsp_data.phase_out !== want.phase_out || rsp_data.status !== want.status ||
                rsp_data.alarm !== want.alarm || rsp_data.trip !== want.trip) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d: got %0d/%0d/%b/%b want %0d/%0d/%b/%b",
                           rsp_beats, rsp_data.phase_out, rsp_data.status, rsp_data.alarm,
                           rsp_data.trip, want.phase_out, want.status, want.alarm, want.trip);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [VOLT_W-1:0] al;
      logic [VOLT_W-1:0] tl;
      logic [NOW_W-1:0]  ap;
      logic [NOW_W-1:0]  tp;
      logic [NOW_W-1:0]  t0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default settings: everything sits in the alarm band, zero periods
      add_sample(3, V_MAX, T_MAX, 1'b1);
      add_sample(3, '0, '0, 1'b0);
      add_sample(0, '0, '0, 1'b1);
      add_sample(0, V_MAX, '0, 1'b1);
      add_sample(1, V_MAX, T_MAX, 1'b0);
      add_sample(1, 32'h8000_0000, T_MAX, 1'b1);
      add_sample(1, 32'hFFFF_0000, '0, 1'b1);
      wait_idle();

      // band edges, alarm period boundary, trip timer restart, time wrap
      apply_setting(32'h0001_0000, 32'h0010_0000, 48'd10, T_MAX);
      add_sample(0, 32'h0000_FFFF, 48'd100, 1'b1);
      add_sample(0, 32'h0001_0000, 48'd100, 1'b1);
      add_sample(0, 32'h0010_0000, 48'd109, 1'b1);
      add_sample(0, 32'h0010_0000, 48'd110, 1'b1);
      add_sample(0, 32'h0010_0001, 48'd111, 1'b1);
      add_sample(0, V_MAX, 48'd200, 1'b1);
      add_sample(0, 32'h0002_0000, 48'd205, 1'b1);
      add_sample(0, 32'h0010_0001, 48'd206, 1'b1);
      add_sample(0, '0, 48'd207, 1'b1);
      add_sample(1, '0, '0, 1'b1);
      add_sample(1, 32'h0002_0000, T_MAX - 4, 1'b1);
      add_sample(1, 32'h0002_0000, 48'd5, 1'b1);
      wait_idle();

      for (int p = 0; p < NPH; p++) gen_t[p] = T_MAX - NOW_W'($urandom_range(4000, 0));

      al = $urandom_range(32'h7FFF_FFFF, 32'h1000_0000);
      tl = $urandom_range(32'hEFFF_FFFF, al + 1);
      ap = NOW_W'($urandom_range(400, 1));
      tp = 48'h0100_0000_0000 | {16'($urandom), $urandom};
      apply_setting(al, tl, ap, tp);
      adv_max = ap[15:0] / 4 + 2;
      random_stream(500);
      wait_idle();

      apply_setting(V_MAX, V_MAX, T_MAX, T_MAX);
      adv_max = 1000;
      random_stream(300);
      wait_idle();

      apply_setting('0, '0, '0, T_MAX);
      adv_max = 50;
      random_stream(400);
      wait_idle();

      al = $urandom;
      tl = $urandom;
      ap = NOW_W'($urandom_range(50, 0));
      tp = {1'b1, 15'($urandom), $urandom};
      apply_setting(al, tl, ap, tp);
      adv_max = 20;
      random_stream(500);
      wait_idle();

      // trip period boundary across the time wrap, then the latched relay
      ap = NOW_W'($urandom_range(30, 1));
      tp = NOW_W'($urandom_range(200, 20));
      t0 = T_MAX - NOW_W'($urandom_range(15, 0));
      apply_setting(32'h0100_0000, 32'h0200_0000, ap, tp);
      add_sample(0, '0, t0, 1'b1);
      add_sample(2, '0, t0, 1'b1);
      add_sample(2, V_MAX, t0, 1'b1);
      add_sample(0, 32'h0200_0001, t0, 1'b1);
      add_sample(2, V_MAX, t0 + tp - 1, 1'b1);
      add_sample(2, 32'h0300_0000, t0 + tp, 1'b1);
      add_sample(0, 32'h0200_0001, t0 + tp, 1'b1);
      add_sample(3, '0, t0, 1'b1);
      adv_max = 20;
      random_stream(150);
      wait_idle();

      if (mismatches == 0 && status_due_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ovtr_pkg.sv
rtl/ovtr_eval.sv
rtl/ovtr_state.sv
rtl/overvoltage_alarm_trip_relay_unit.sv
tb/sv/tb_top.sv
